>>> design/isl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isl_pkg: shared definitions for the indexed shift list
// request kinds, status codes and stream field widths
// ----------------------------------------------------------------------------
package isl_pkg;

  localparam int unsigned KIND_W      = 3;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

endpackage

>>> design/isl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isl_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module isl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/indexed_shift_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_shift_list: bounded ordered list of words with a live count
// append, read, write, remove and insert by index over a single ram
// ----------------------------------------------------------------------------
// usage
//   requests enter on the s_axis group: tuser carries the kind, tdata the
//   index and the word. one response per request leaves on the m_axis group
//   with the word read or removed, a status and the live count afterwards.
//   the list lives in one ram with one read and one write port; a small
//   sequencer moves one word at a time, read then written, when remove or
//   insert close or open a gap, so s_axis_tready is low while a request is
//   in progress.
// states per request: append, write, refused or unused kinds and insert at
//   the end pass done; read passes fetch, hold and done; remove passes fetch
//   and hold, then rd and wr for each word that moves down, then done;
//   insert at i < n passes rd and wr for each word that moves up, then ins and done
// the response turns valid in the same cycle that the next request can be taken
// the response sits in an output register, so the next request is taken
// while the previous response waits; if the receiver stalls and a second
// response is ready, the sequencer holds it until the register frees up.
// reset clears the live count and the control state; ram contents are not
// cleared, entries above the live count are never visible.
// ----------------------------------------------------------------------------
module indexed_shift_list #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // index [3:0], value [35:4], zero [39:36]
  input  logic [isl_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // kind [2:0]
  input  logic [isl_pkg::KIND_W-1:0]         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // read_value [31:0], status [33:32], count [38:34], zero [39]
  output logic [isl_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  import isl_pkg::*;

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > IDX_W) ? CW : IDX_W;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_FETCH = 7'b0000010,
    ST_HOLD  = 7'b0000100,
    ST_RD    = 7'b0001000,
    ST_WR    = 7'b0010000,
    ST_INS   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e                state_q, state_d;
  logic [KIND_W-1:0]     kind_q, kind_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [CW-1:0]         ptr_q, ptr_d;
  logic [CW-1:0]         count_q, count_d;
  logic [DATA_WIDTH-1:0] word_q, word_d;
  logic [DATA_WIDTH-1:0] rv_q, rv_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic                  out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  logic [IDX_W-1:0]      in_index;
  logic [63:0]           in_value64;
  logic [DATA_WIDTH-1:0] in_word;
  logic [CMPW-1:0]       idx_c;
  logic [CMPW-1:0]       count_c;
  logic                  list_full;
  logic                  accept;
  logic [CW:0]           ptr_p1, ptr_p2, count_x;
  logic [CW-1:0]         ptr_m1;
  logic [63:0]           rv64;
  logic [31:0]           count32;

  assign in_index   = s_axis_tdata[IDX_W-1:0];
  assign in_value64 = {32'b0, s_axis_tdata[IDX_W+VAL_W-1:IDX_W]};
  assign in_word    = in_value64[DATA_WIDTH-1:0];
  assign idx_c      = CMPW'(in_index);
  assign count_c    = CMPW'(count_q);
  assign list_full  = (count_c == CMPW'(DEPTH));

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign ptr_p1  = {1'b0, ptr_q} + (CW+1)'(1);
  assign ptr_p2  = {1'b0, ptr_q} + (CW+1)'(2);
  assign ptr_m1  = ptr_q - CW'(1);
  assign count_x = {1'b0, count_q};

  assign rv64    = 64'(rv_q);
  assign count32 = 32'(count_q);

  // read address: fetch the addressed word, or the neighbour that moves
  always_comb begin
    if (state_q == ST_RD) begin
      if (kind_q == KIND_REMOVE) begin
        ram_raddr = ptr_p1[AW-1:0];
      end else begin
        ram_raddr = ptr_m1[AW-1:0];
      end
    end else begin
      ram_raddr = ptr_q[AW-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    idx_d       = idx_q;
    ptr_d       = ptr_q;
    count_d     = count_q;
    word_d      = word_q;
    rv_d        = rv_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = ptr_q[AW-1:0];
    ram_wdata   = ram_rdata;

    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          kind_d   = s_axis_tuser;
          idx_d    = idx_c[CW-1:0];
          ptr_d    = idx_c[CW-1:0];
          word_d   = in_word;
          rv_d     = '0;
          status_d = STATUS_OK;
          state_d  = ST_DONE;
          case (s_axis_tuser)
            KIND_APPEND: begin
              if (list_full) begin
                status_d = STATUS_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_q[AW-1:0];
                ram_wdata = in_word;
                count_d   = count_q + CW'(1);
              end
            end
            KIND_READ, KIND_REMOVE: begin
              if (idx_c >= count_c) begin
                status_d = STATUS_RANGE;
              end else begin
                state_d = ST_FETCH;
              end
            end
            KIND_WRITE: begin
              if (idx_c >= count_c) begin
                status_d = STATUS_RANGE;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = idx_c[AW-1:0];
                ram_wdata = in_word;
              end
            end
            KIND_INSERT: begin
              if (idx_c > count_c) begin
                status_d = STATUS_RANGE;
              end else if (list_full) begin
                status_d = STATUS_FULL;
              end else if (idx_c == count_c) begin
                ram_we    = 1'b1;
                ram_waddr = count_q[AW-1:0];
                ram_wdata = in_word;
                count_d   = count_q + CW'(1);
              end else begin
                // open the gap from the top end downwards
                ptr_d   = count_q;
                state_d = ST_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_FETCH: begin
        state_d = ST_HOLD;
      end
      ST_HOLD: begin
        rv_d = ram_rdata;
        if (kind_q == KIND_REMOVE) begin
          if (ptr_p1 < count_x) begin
            state_d = ST_RD;
          end else begin
            count_d = count_q - CW'(1);
            state_d = ST_DONE;
          end
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_RD: begin
        state_d = ST_WR;
      end
      ST_WR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q[AW-1:0];
        ram_wdata = ram_rdata;
        if (kind_q == KIND_REMOVE) begin
          ptr_d = ptr_p1[CW-1:0];
          if (ptr_p2 < count_x) begin
            state_d = ST_RD;
          end else begin
            count_d = count_q - CW'(1);
            state_d = ST_DONE;
          end
        end else begin
          ptr_d = ptr_m1;
          if (ptr_m1 > idx_q) begin
            state_d = ST_RD;
          end else begin
            state_d = ST_INS;
          end
        end
      end
      ST_INS: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AW-1:0];
        ram_wdata = word_q;
        count_d   = count_q + CW'(1);
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {1'b0, count32[COUNT_W-1:0], status_q, rv64[VAL_W-1:0]};
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    idx_q      <= idx_d;
    ptr_q      <= ptr_d;
    word_q     <= word_d;
    rv_q       <= rv_d;
    status_q   <= status_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  isl_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

>>> design/isl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isl_checker: port-level checks for the indexed shift list
// request and response handshake, consistency of status, word and count
// ----------------------------------------------------------------------------
module isl_checker #(
  parameter int unsigned DEPTH = 16
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [isl_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic [isl_pkg::KIND_W-1:0]      s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [isl_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  import isl_pkg::*;

  logic [STATUS_W-1:0] rsp_status;
  logic [COUNT_W-1:0]  rsp_count;
  logic [VAL_W-1:0]    rsp_value;

  assign rsp_value  = m_axis_tdata[VAL_W-1:0];
  assign rsp_status = m_axis_tdata[VAL_W+STATUS_W-1:VAL_W];
  assign rsp_count  = m_axis_tdata[VAL_W+STATUS_W+COUNT_W-1:VAL_W+STATUS_W];

  // a waiting request is held with its payload until taken
  a_req_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready
      |=> s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
    else $error("request changed while waiting");

  // stalled response stays valid
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("response dropped while stalled");

  // stalled response keeps its payload
  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("response payload changed while stalled");

  // refused requests return no word
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (rsp_status == STATUS_RANGE || rsp_status == STATUS_FULL)
      |-> rsp_value == '0)
    else $error("refused request returned a word");

  // status is a known code and the count stays within capacity
  a_status_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (rsp_status != 2'd3) && (32'(rsp_count) <= 32'(DEPTH)))
    else $error("bad status or count beyond capacity");

endmodule

bind indexed_shift_list isl_checker #(
  .DEPTH (DEPTH)
) u_isl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
